[design/nav_frame_bit_stream_crc24_assert.svh]
// Assertion macros used by the frame bit generator top level.
`ifndef NAV_FRAME_BIT_STREAM_CRC24_ASSERT_SVH
`define NAV_FRAME_BIT_STREAM_CRC24_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFBS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/nfbs_pkg.sv]
// Package with types, constants and the message bit function of the frame bit generator.
package nfbs_pkg;

  localparam int unsigned ChannelCount = 64;
  localparam int unsigned ChanW        = 6;
  localparam int unsigned PosW         = 9;
  localparam int unsigned CrcW         = 24;

  localparam logic [24:0]     CrcPolyFull = 25'h1864CFB;
  localparam logic [CrcW-1:0] CrcMask     = 24'hFFFFFF;
  localparam logic [7:0]      Preamble    = 8'b1000_1011;
  localparam logic [7:0]      MsgType     = 8'd31;
  localparam logic [PosW-1:0] CrcStart    = 9'd276;
  localparam logic [PosW-1:0] FrameLast   = 9'd299;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [CrcW-1:0] crc;
  } chan_state_t;

  function automatic logic msg_bit(input logic [PosW-1:0] pos, input logic [ChanW-1:0] ch);
    logic [2:0] idx;
    logic       b;
    idx = ~pos[2:0];
    if (pos < 9'd8) begin
      b = Preamble[idx];
    end else if (pos < 9'd16) begin
      b = MsgType[idx];
    end else if (pos < 9'd22) begin
      b = ch[3'(3'd5 - pos[2:0])];
    end else begin
      b = 1'b0;
    end
    return b;
  endfunction

endpackage

[design/nfbs_chan_ram.sv]
// Per-channel state memory with valid bits and write-to-read forwarding.
module nfbs_chan_ram #(
  parameter int unsigned Depth = nfbs_pkg::ChannelCount,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  nfbs_pkg::chan_state_t wr_data_i,
  output nfbs_pkg::chan_state_t rd_data_o
);

  nfbs_pkg::chan_state_t mem_q [Depth];
  nfbs_pkg::chan_state_t rd_q;
  nfbs_pkg::chan_state_t fwd_data_q;
  logic [Depth-1:0]      vld_q;
  logic                  vld_rd_q;
  logic                  fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_rd_q <= vld_q[rd_addr_i];
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (vld_rd_q ? rd_q : '0);

endmodule

[design/nfbs_step.sv]
// Next-bit logic: message bit selection, serial CRC-24Q update and frame wrap.
module nfbs_step (
  input  logic [nfbs_pkg::ChanW-1:0] channel_i,
  input  nfbs_pkg::chan_state_t      state_i,
  output logic                       frame_bit_o,
  output logic                       frame_end_o,
  output nfbs_pkg::chan_state_t      state_o
);

  logic [nfbs_pkg::PosW-1:0] pos;
  logic [nfbs_pkg::CrcW-1:0] crc;
  logic [nfbs_pkg::CrcW-1:0] crc_nxt;
  logic [4:0]                crc_idx;
  logic                      fb;
  logic                      last;

  always_comb begin
    pos     = (state_i.pos > nfbs_pkg::FrameLast) ? nfbs_pkg::FrameLast : state_i.pos;
    crc     = (state_i.pos == '0) ? '0 : state_i.crc;
    crc_idx = 5'(nfbs_pkg::FrameLast - pos);
    crc_nxt = crc;
    if (pos < nfbs_pkg::CrcStart) begin
      fb      = nfbs_pkg::msg_bit(pos, channel_i);
      crc_nxt = {crc[nfbs_pkg::CrcW-2:0], 1'b0} & nfbs_pkg::CrcMask;
      if (crc[nfbs_pkg::CrcW-1] ^ fb) begin
        crc_nxt = crc_nxt ^ nfbs_pkg::CrcPolyFull[nfbs_pkg::CrcW-1:0];
      end
    end else begin
      fb = crc[crc_idx];
    end
    last = (pos == nfbs_pkg::FrameLast);
    if (last) begin
      state_o = '0;
    end else begin
      state_o.pos = pos + 9'd1;
      state_o.crc = crc_nxt;
    end
  end

  assign frame_bit_o = fb;
  assign frame_end_o = last;

endmodule

[design/nav_frame_bit_stream_crc24.sv]
// Top level of the per-channel navigation frame bit generator with CRC-24Q.
// Each request names a channel and returns one result: that channel's next bit of its
// repeating 300-bit frame, with frame_end set on the last bit. One request is accepted
// every cycle while the output drains. An accepted request waits in the request stage
// while its state is read; its result is registered once the output is free. The rate
// is set by the per-channel state memory, which is read once when a request is accepted
// and written once when its result is produced, with the write forwarded to a read of
// the same channel in the same cycle. Channel state comes out of reset cleared through
// per-channel valid bits, so the block is ready at once with no clearing pass.
`include "nav_frame_bit_stream_crc24_assert.svh"

module nav_frame_bit_stream_crc24 #(
  parameter int unsigned CHANNEL_COUNT = nfbs_pkg::ChannelCount
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [nfbs_pkg::ChanW-1:0] channel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       frame_bit_o,
  output logic                       frame_end_o
);

  localparam int unsigned AddrW = $clog2(CHANNEL_COUNT);
  localparam logic [nfbs_pkg::ChanW-1:0] MaxCh = nfbs_pkg::ChanW'(CHANNEL_COUNT - 1);

  logic                       accept;
  logic                       fire;
  logic [nfbs_pkg::ChanW-1:0] ch_clamped;
  logic                       s1_v_q, s1_v_d;
  logic [nfbs_pkg::ChanW-1:0] ch_q;
  logic                       out_v_q, out_v_d;
  logic                       bit_q, end_q;
  logic                       step_bit, step_end;
  nfbs_pkg::chan_state_t      cur_state;
  nfbs_pkg::chan_state_t      nxt_state;

  always_comb begin
    ch_clamped = (channel_i == '0) ? nfbs_pkg::ChanW'(1) : channel_i;
    if (ch_clamped > MaxCh) begin
      ch_clamped = MaxCh;
    end
  end

  assign fire       = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  assign s1_v_d  = accept ? 1'b1 : (fire ? 1'b0 : s1_v_q);
  assign out_v_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= ch_clamped;
    end
    if (fire) begin
      bit_q <= step_bit;
      end_q <= step_end;
    end
  end

  nfbs_chan_ram #(
    .Depth(CHANNEL_COUNT)
  ) u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(ch_clamped[AddrW-1:0]),
    .wr_en_i  (fire),
    .wr_addr_i(ch_q[AddrW-1:0]),
    .wr_data_i(nxt_state),
    .rd_data_o(cur_state)
  );

  nfbs_step u_step (
    .channel_i  (ch_q),
    .state_i    (cur_state),
    .frame_bit_o(step_bit),
    .frame_end_o(step_end),
    .state_o    (nxt_state)
  );

  assign out_valid_o = out_v_q;
  assign frame_bit_o = bit_q;
  assign frame_end_o = end_q;

  `NFBS_ASSERT_SAME(a_free_output_fires, s1_v_q && !out_v_q, fire, "request held with free output")
  `NFBS_ASSERT_NEXT(a_fire_gives_result, fire, out_v_q, "result missing after fire")
  `NFBS_ASSERT_NEXT(a_frame_start_bit, fire && (cur_state.pos == '0), out_v_q && bit_q, "frame did not open with preamble one")
  `NFBS_ASSERT_SAME(a_pos_in_frame, fire, nxt_state.pos <= nfbs_pkg::FrameLast, "next position beyond frame")

endmodule
